@@ hdl/heightmap_face_normal_stream_core_assert.svh @@
// Assertion macros shared by the heightmap face normal stream design.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef HEIGHTMAP_FACE_NORMAL_STREAM_CORE_ASSERT_SVH
`define HEIGHTMAP_FACE_NORMAL_STREAM_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define HFNS_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`define HFNS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define HFNS_ASSERT_SAME(lbl, pre, post, msg)

`define HFNS_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

@@ hdl/hfns_pkg.sv @@
`timescale 1ns / 1ps

package hfns_pkg;

  localparam logic [15:0] VOID_LIMIT = 16'd64000;
  localparam logic [14:0] Q_ONE      = 15'd16384;
  localparam int          QDEPTH     = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROW_LENGTH     = 3'd0;
  localparam logic [2:0] REG_SKIP_ROW_FIRST = 3'd1;
  localparam logic [2:0] REG_SKIP_ROW_LAST  = 3'd2;
  localparam logic [2:0] REG_SKIP_COL_FIRST = 3'd3;
  localparam logic [2:0] REG_SKIP_COL_LAST  = 3'd4;

  localparam logic [12:0] RST_ROW_LENGTH     = 13'd3601;
  localparam logic [11:0] RST_SKIP_ROW_FIRST = 12'd139;
  localparam logic [11:0] RST_SKIP_ROW_LAST  = 12'd151;
  localparam logic [11:0] RST_SKIP_COL_FIRST = 12'd120;
  localparam logic [11:0] RST_SKIP_COL_LAST  = 12'd169;

  typedef struct packed {
    logic [15:0] height_word;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [11:0]        cell_row;
    logic [11:0]        cell_col;
    logic signed [15:0] upper_nx;
    logic [14:0]        upper_ny;
    logic signed [15:0] upper_nz;
    logic signed [15:0] lower_nx;
    logic [14:0]        lower_ny;
    logic signed [15:0] lower_nz;
  } out_t;

  // One classified cell: its position and the height differences of both triangles.
  typedef struct packed {
    logic [11:0]        row;
    logic [11:0]        col;
    logic signed [16:0] dx_u;
    logic signed [16:0] dz_u;
    logic signed [16:0] dx_l;
    logic signed [16:0] dz_l;
  } cell_t;

endpackage

@@ hdl/hfns_ram.sv @@
`timescale 1ns / 1ps

module hfns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hfns_fifo.sv @@
`timescale 1ns / 1ps

module hfns_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hfns_pkg::cell_t wdata,
  output logic          full,
  input  logic          pop,
  output hfns_pkg::cell_t rdata,
  output logic          empty
);

  localparam int AW = $clog2(hfns_pkg::QDEPTH);

  hfns_pkg::cell_t entry_r [hfns_pkg::QDEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full  = (count_r == (AW+1)'(hfns_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push && !full) begin
      wptr_nxt = (wptr_r == AW'(hfns_pkg::QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rptr_nxt = (rptr_r == AW'(hfns_pkg::QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/hfns_front.sv @@
`timescale 1ns / 1ps

module hfns_front #(
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  hfns_pkg::in_t   in_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  output logic            q_push,
  output hfns_pkg::cell_t q_data,
  input  logic            q_full
);

  localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam logic [12:0] LEN_MAX = 13'(MAX_ROW_LENGTH);

  logic [12:0] row_length_r;
  logic [11:0] skip_row_first_r, skip_row_last_r, skip_col_first_r, skip_col_last_r;
  logic        busy_r;
  logic [15:0] h_r;
  logic        fs_r;
  logic [11:0] row_r, row_nxt;
  logic [11:0] col_r, col_nxt;
  logic [15:0] left_r, ul_r;

  logic        accept;
  logic [AW-1:0] rd_addr;
  logic [15:0] above;
  logic [12:0] len;
  logic [11:0] row_e, col_e;
  logic [12:0] col_inc;
  logic [11:0] r_cell, c_cell;
  logic        has_cell, skip;

  assign cfg_ready = 1'b1;
  assign in_full   = busy_r || q_full;
  assign accept    = in_push && !in_full;
  assign rd_addr   = in_data.frame_start ? '0 : col_r[AW-1:0];

  hfns_ram #(.WIDTH(16), .DEPTH(MAX_ROW_LENGTH)) u_line (
    .clk   (clk),
    .we    (busy_r),
    .waddr (col_e[AW-1:0]),
    .wdata (h_r),
    .raddr (rd_addr),
    .rdata (above)
  );

  always_comb begin
    len = row_length_r;
    if (row_length_r < 13'd2) begin
      len = 13'd2;
    end else if (row_length_r > LEN_MAX) begin
      len = LEN_MAX;
    end
    row_e   = fs_r ? 12'd0 : row_r;
    col_e   = fs_r ? 12'd0 : col_r;
    col_inc = {1'b0, col_e} + 13'd1;
    r_cell  = row_e - 12'd1;
    c_cell  = col_e - 12'd1;
    has_cell = (row_e != 12'd0) && (col_e != 12'd0);
    skip = (r_cell >= skip_row_first_r) && (r_cell <= skip_row_last_r) &&
           (c_cell >= skip_col_first_r) && (c_cell <= skip_col_last_r);
    if (col_inc >= len) begin
      col_nxt = 12'd0;
      row_nxt = row_e + 12'd1;
    end else begin
      col_nxt = col_inc[11:0];
      row_nxt = row_e;
    end
  end

  // Corner naming: h00 upper left, h01 above, h10 left, h11 current sample.
  assign q_push      = busy_r && has_cell && !skip;
  assign q_data.row  = r_cell;
  assign q_data.col  = c_cell;
  assign q_data.dx_u = $signed({1'b0, ul_r}) - $signed({1'b0, above});
  assign q_data.dz_u = $signed({1'b0, ul_r}) - $signed({1'b0, left_r});
  assign q_data.dx_l = $signed({1'b0, left_r}) - $signed({1'b0, h_r});
  assign q_data.dz_l = $signed({1'b0, above}) - $signed({1'b0, h_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r     <= hfns_pkg::RST_ROW_LENGTH;
      skip_row_first_r <= hfns_pkg::RST_SKIP_ROW_FIRST;
      skip_row_last_r  <= hfns_pkg::RST_SKIP_ROW_LAST;
      skip_col_first_r <= hfns_pkg::RST_SKIP_COL_FIRST;
      skip_col_last_r  <= hfns_pkg::RST_SKIP_COL_LAST;
      busy_r           <= 1'b0;
      row_r            <= '0;
      col_r            <= '0;
      left_r           <= '0;
      ul_r             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hfns_pkg::REG_ROW_LENGTH:     row_length_r     <= cfg_data;
          hfns_pkg::REG_SKIP_ROW_FIRST: skip_row_first_r <= cfg_data[11:0];
          hfns_pkg::REG_SKIP_ROW_LAST:  skip_row_last_r  <= cfg_data[11:0];
          hfns_pkg::REG_SKIP_COL_FIRST: skip_col_first_r <= cfg_data[11:0];
          hfns_pkg::REG_SKIP_COL_LAST:  skip_col_last_r  <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        left_r <= h_r;
        ul_r   <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r  <= (in_data.height_word > hfns_pkg::VOID_LIMIT) ? 16'd0 : in_data.height_word;
      fs_r <= in_data.frame_start;
    end
  end

endmodule

@@ hdl/hfns_back.sv @@
`timescale 1ns / 1ps

module hfns_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  output logic            q_pop,
  input  hfns_pkg::cell_t q_data,
  output logic            out_empty,
  input  logic            out_pop,
  output hfns_pkg::out_t  out_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQX  = 4'd1;
  localparam logic [3:0] ST_SQZ  = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_INIT = 4'd4;
  localparam logic [3:0] ST_MID  = 4'd5;
  localparam logic [3:0] ST_MLO  = 4'd6;
  localparam logic [3:0] ST_MHI  = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]  state_r;
  logic        tri_r;
  logic [1:0]  comp_r;
  logic        out_valid_r;
  hfns_pkg::cell_t ent_r;
  hfns_pkg::out_t  out_r;
  logic [31:0] xx_r, zz_r, cc_r;
  logic [32:0] s_r;
  logic [14:0] lo_r, hi_r, mid_r;
  logic [29:0] tt_r;
  logic [45:0] plo_r;
  logic [46:0] phi_r;
  logic signed [15:0] nx_r [2];
  logic [14:0]        ny_r [2];
  logic signed [15:0] nz_r [2];

  logic signed [16:0] sel_x, sel_z;
  logic [16:0] abs_x, abs_z;
  logic [15:0] mid_sum;
  logic [14:0] mid;
  logic [15:0] t2;
  logic [14:0] t;
  logic [63:0] prod, rhs;
  logic [15:0] sgn_val;
  logic        neg;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    sel_x   = tri_r ? ent_r.dx_l : ent_r.dx_u;
    sel_z   = tri_r ? ent_r.dz_l : ent_r.dz_u;
    abs_x   = sel_x[16] ? 17'(-sel_x) : sel_x;
    abs_z   = sel_z[16] ? 17'(-sel_z) : sel_z;
    mid_sum = 16'(lo_r) + 16'(hi_r) + 16'd1;
    mid     = mid_sum[15:1];
    t2      = {mid, 1'b0} - 16'd1;
    t       = t2[14:0];
    prod    = (64'(phi_r) << 16) + 64'(plo_r);
    rhs     = 64'(cc_r) << 30;
    neg     = (comp_r == 2'd0) ? sel_x[16] : sel_z[16];
    sgn_val = neg ? (16'd0 - {1'b0, lo_r}) : {1'b0, lo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tri_r       <= 1'b0;
      comp_r      <= '0;
    end else begin
      if ((state_r == ST_DONE) && (!out_valid_r || out_pop)) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            tri_r   <= 1'b0;
            state_r <= ST_SQX;
          end
        end
        ST_SQX:  state_r <= ST_SQZ;
        ST_SQZ:  state_r <= ST_SUM;
        ST_SUM: begin
          comp_r  <= 2'd0;
          state_r <= ST_INIT;
        end
        ST_INIT: state_r <= ST_MID;
        ST_MID: begin
          if (lo_r >= hi_r) begin
            if (comp_r != 2'd2) begin
              comp_r  <= comp_r + 2'd1;
              state_r <= ST_INIT;
            end else if (!tri_r) begin
              tri_r   <= 1'b1;
              state_r <= ST_SQX;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            state_r <= ST_MLO;
          end
        end
        ST_MLO:  state_r <= ST_MHI;
        ST_MHI:  state_r <= ST_CMP;
        ST_CMP:  state_r <= ST_MID;
        ST_DONE: begin
          if (!out_valid_r || out_pop) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Each magnitude is the largest m with (2m-1)^2 * S <= (2^15 * c)^2, found by bisection.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          ent_r <= q_data;
        end
      end
      ST_SQX: xx_r <= abs_x[15:0] * abs_x[15:0];
      ST_SQZ: zz_r <= abs_z[15:0] * abs_z[15:0];
      ST_SUM: s_r  <= 33'(xx_r) + 33'(zz_r) + 33'd1;
      ST_INIT: begin
        case (comp_r)
          2'd0:    cc_r <= xx_r;
          2'd1:    cc_r <= 32'd1;
          default: cc_r <= zz_r;
        endcase
        lo_r <= '0;
        hi_r <= hfns_pkg::Q_ONE;
      end
      ST_MID: begin
        if (lo_r >= hi_r) begin
          case (comp_r)
            2'd0:    nx_r[tri_r] <= sgn_val;
            2'd1:    ny_r[tri_r] <= lo_r;
            default: nz_r[tri_r] <= sgn_val;
          endcase
        end else begin
          mid_r <= mid;
          tt_r  <= t * t;
        end
      end
      ST_MLO: plo_r <= tt_r * s_r[15:0];
      ST_MHI: phi_r <= tt_r * s_r[32:16];
      ST_CMP: begin
        if (prod <= rhs) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r - 15'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_r.cell_row <= ent_r.row;
          out_r.cell_col <= ent_r.col;
          out_r.upper_nx <= nx_r[0];
          out_r.upper_ny <= ny_r[0];
          out_r.upper_nz <= nz_r[0];
          out_r.lower_nx <= nx_r[1];
          out_r.lower_ny <= ny_r[1];
          out_r.lower_nz <= nz_r[1];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/heightmap_face_normal_stream_core.sv @@
// Heightmap face normal stream: takes row-major 16-bit elevation samples (values above
// 64000 count as 0) and, for every grid cell outside the configured cut-out, gives the
// cell's row and column and the Q1.14 unit normals of its two triangles. The front end
// takes a sample, reads the line buffer, then writes it before taking the next, and hands
// cells to a two-entry queue. The back end normalizes one cell at a time with a single
// bisection unit stepping through MID, MLO, MHI and CMP for each of six components; it
// sets the sustained rate whenever results are produced. Samples with no result (first
// row, first column, cut-out) pass at the front end rate while the queue has space.
`timescale 1ns / 1ps

`include "heightmap_face_normal_stream_core_assert.svh"

module heightmap_face_normal_stream_core #(
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  hfns_pkg::in_t  in_data,
  output logic           out_empty,
  input  logic           out_pop,
  output hfns_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [12:0]    cfg_data
);

  logic            q_push, q_full, q_pop, q_empty;
  hfns_pkg::cell_t q_wdata, q_rdata;

  hfns_front #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  hfns_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  hfns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // A cell is never pushed into a full queue; space was checked when its sample came in.
  `HFNS_ASSERT_SAME(a_no_push_full, q_push, !q_full, "cell pushed into full queue")
  `HFNS_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "cell popped from empty queue")
  // The front end finishes a sample before it takes the next one.
  `HFNS_ASSERT_NEXT(a_accept_busy, in_push && !in_full, in_full, "sample taken while busy")

endmodule
